[hdl/assert_macros.svh]
// Assertion macros shared by the decoder RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that an expression holds on every clock edge out of reset.
`define ASSERT_ALWAYS(lbl, clk, rstn, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (expr)) else $error(msg);

// Check a consequent in the same cycle as its antecedent.
`define ASSERT_IMPLY(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Check a consequent in the cycle after its antecedent.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/b85d_pkg.sv]
// Types, constants and tables for the base-85 string decoder.
package b85d_pkg;

    localparam int CHAR_W      = 8;
    localparam int GROUP_W     = 32;
    localparam int DIGIT_W     = 7;
    localparam int COUNT_W     = 3;
    localparam int PROD_W      = GROUP_W + DIGIT_W;
    localparam int PAD_W       = 27;
    localparam int SCALE_W     = 26;
    localparam int PADPROD_W   = PAD_W + SCALE_W;
    localparam int LANES       = 4;
    localparam int LANE_W      = 2;
    localparam int CHAIN_DEPTH = 8;
    localparam int FILL_W      = 4;

    localparam logic [DIGIT_W-1:0] RADIX        = 7'd85;
    localparam logic [DIGIT_W-1:0] TOP_DIGIT    = 7'd84;
    localparam logic [DIGIT_W-1:0] BAD_DIGIT    = 7'd85;
    localparam logic [COUNT_W-1:0] GROUP_DIGITS = 3'd5;
    localparam logic [COUNT_W-1:0] GROUP_BYTES  = 3'd4;

    typedef struct packed {
        logic [CHAR_W-1:0] char_code;
        logic              string_end;
    } in_word_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       has_byte;
        logic       bad_string;
        logic       string_done;
        logic       run_last;
    } out_word_t;

    typedef enum logic [1:0] {
        EV_ERROR,
        EV_FULL,
        EV_PART
    } event_kind_t;

    typedef struct packed {
        logic load;
        logic shift;
    } cell_ctl_t;

    localparam out_word_t ERR_WORD = '{data_byte: 8'h00, has_byte: 1'b0, bad_string: 1'b1,
                                       string_done: 1'b1, run_last: 1'b1};
    localparam out_word_t MARK_WORD = '{data_byte: 8'h00, has_byte: 1'b0, bad_string: 1'b0,
                                        string_done: 1'b1, run_last: 1'b1};

    function automatic logic [DIGIT_W-1:0] digit_of(input logic [CHAR_W-1:0] c);
        logic [DIGIT_W-1:0] d;
        case (c) inside
            [8'h30:8'h39]: d = DIGIT_W'(c - 8'h30);
            [8'h41:8'h5A]: d = DIGIT_W'(c - 8'h41 + 8'd10);
            [8'h61:8'h7A]: d = DIGIT_W'(c - 8'h61 + 8'd36);
            8'h21: d = 7'd62;
            8'h23: d = 7'd63;
            8'h24: d = 7'd64;
            8'h25: d = 7'd65;
            8'h26: d = 7'd66;
            8'h28: d = 7'd67;
            8'h29: d = 7'd68;
            8'h2A: d = 7'd69;
            8'h2B: d = 7'd70;
            8'h2D: d = 7'd71;
            8'h3B: d = 7'd72;
            8'h3C: d = 7'd73;
            8'h3D: d = 7'd74;
            8'h3E: d = 7'd75;
            8'h3F: d = 7'd76;
            8'h40: d = 7'd77;
            8'h5E: d = 7'd78;
            8'h5F: d = 7'd79;
            8'h60: d = 7'd80;
            8'h7B: d = 7'd81;
            8'h7C: d = 7'd82;
            8'h7D: d = 7'd83;
            8'h7E: d = 7'd84;
            default: d = BAD_DIGIT;
        endcase
        return d;
    endfunction

    // 85 to the power of the number of pad digits a group of k digits needs
    function automatic logic [SCALE_W-1:0] pad_scale(input logic [COUNT_W-1:0] k);
        logic [SCALE_W-1:0] s;
        case (k)
            3'd1: s = 26'd52200625;
            3'd2: s = 26'd614125;
            3'd3: s = 26'd7225;
            3'd4: s = 26'd85;
            default: s = 26'd1;
        endcase
        return s;
    endfunction

endpackage

[hdl/b85d_cell.sv]
// One result cell of the output chain: load from the insert lanes or take the neighbor's word.
module b85d_cell (
    input  logic                 aclk,
    input  b85d_pkg::cell_ctl_t  ctl,
    input  b85d_pkg::out_word_t  load_word,
    input  b85d_pkg::out_word_t  next_word,
    output b85d_pkg::out_word_t  word
);

    b85d_pkg::out_word_t word_reg;

    always_ff @(posedge aclk) begin
        if (ctl.load) begin
            word_reg <= load_word;
        end else if (ctl.shift) begin
            word_reg <= next_word;
        end
    end

    assign word = word_reg;

endmodule

[hdl/b85d_chain.sv]
// Row of result cells that collapses toward the head and takes up to four words per cycle.
module b85d_chain (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  logic                                    ins_valid,
    input  logic [b85d_pkg::COUNT_W-1:0]            ins_count,
    input  b85d_pkg::out_word_t [b85d_pkg::LANES-1:0] ins_lanes,
    output logic [b85d_pkg::FILL_W-1:0]             room,
    output logic                                    m_valid,
    input  logic                                    m_ready,
    output b85d_pkg::out_word_t                     m_data
);

    logic [b85d_pkg::FILL_W-1:0] fill_reg;
    logic [b85d_pkg::FILL_W-1:0] fill_next;
    logic [b85d_pkg::FILL_W-1:0] base;
    logic                        pop;

    b85d_pkg::out_word_t       cell_word [b85d_pkg::CHAIN_DEPTH];
    b85d_pkg::out_word_t       cell_next [b85d_pkg::CHAIN_DEPTH];
    b85d_pkg::out_word_t       cell_load [b85d_pkg::CHAIN_DEPTH];
    b85d_pkg::cell_ctl_t       cell_ctl  [b85d_pkg::CHAIN_DEPTH];
    logic [b85d_pkg::FILL_W-1:0] cell_rel [b85d_pkg::CHAIN_DEPTH];

    assign pop       = (fill_reg != '0) && m_ready;
    assign base      = fill_reg - b85d_pkg::FILL_W'(pop);
    assign fill_next = base + (ins_valid ? b85d_pkg::FILL_W'(ins_count) : '0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg <= '0;
        end else begin
            fill_reg <= fill_next;
        end
    end

    for (genvar j = 0; j < b85d_pkg::CHAIN_DEPTH; j++) begin : g_cell
        always_comb begin
            cell_rel[j]       = b85d_pkg::FILL_W'(j) - base;
            cell_ctl[j].load  = ins_valid && (cell_rel[j] < b85d_pkg::FILL_W'(ins_count));
            cell_ctl[j].shift = pop;
            cell_load[j]      = ins_lanes[cell_rel[j][b85d_pkg::LANE_W-1:0]];
        end

        if (j == b85d_pkg::CHAIN_DEPTH - 1) begin : g_tail
            assign cell_next[j] = '0;
        end else begin : g_body
            assign cell_next[j] = cell_word[j+1];
        end

        b85d_cell u_cell (
            .aclk      (aclk),
            .ctl       (cell_ctl[j]),
            .load_word (cell_load[j]),
            .next_word (cell_next[j]),
            .word      (cell_word[j])
        );
    end

    assign room    = b85d_pkg::FILL_W'(b85d_pkg::CHAIN_DEPTH) - fill_reg;
    assign m_valid = fill_reg != '0;
    assign m_data  = cell_word[0];

endmodule

[hdl/base85_string_decoder.sv]
// Top level of the base-85 string decoder: digit accumulator, pad multiplier and result chain.
//
// Input channel s_*: one character word per handshake, with string_end on the last
// character of a string. Result channel m_*: one result word per handshake, a decoded
// byte or a marker (error, or end of a string that yields no bytes).
// A character is taken every cycle while s_ready is high. Its first result passes
// the accumulator output register, the pad multiplier register, then the head of an
// eight-cell result chain before it appears on m_*.
// Sustained rate is one character per cycle while m_ready is high; a full group of five
// characters produces four bytes in one burst that the chain drains one word per cycle.
// s_ready falls only when the chain lacks room for the pending burst, which happens
// when m_ready is held low or results pile up faster than one per cycle.
// While m_ready is low the head word holds on m_data and nothing is lost.
// Reset clears the group value, digit count, rejected-string flag, both pipeline
// valid bits and the chain fill count; the next character starts a new string.
`include "assert_macros.svh"

module base85_string_decoder (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  b85d_pkg::in_word_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output b85d_pkg::out_word_t m_data
);

    // accumulator state
    logic [b85d_pkg::GROUP_W-1:0] group_reg, group_next;
    logic [b85d_pkg::COUNT_W-1:0] digits_reg, digits_next;
    logic                         failed_reg, failed_next;

    logic                         accept;
    logic [b85d_pkg::DIGIT_W-1:0] digit;
    logic [b85d_pkg::PROD_W-1:0]  prod;
    logic [b85d_pkg::COUNT_W-1:0] count_inc;

    logic                         ev_valid;
    b85d_pkg::event_kind_t        ev_kind;
    logic [b85d_pkg::GROUP_W-1:0] ev_val;
    logic [b85d_pkg::COUNT_W-1:0] ev_k;
    logic                         ev_done;

    // accumulator output stage
    logic                         a_valid_reg, a_valid_next;
    b85d_pkg::event_kind_t        a_kind_reg;
    logic [b85d_pkg::GROUP_W-1:0] a_val_reg;
    logic [b85d_pkg::COUNT_W-1:0] a_k_reg;
    logic                         a_done_reg;

    // pad multiplier stage
    logic                           b_valid_reg, b_valid_next;
    b85d_pkg::event_kind_t          b_kind_reg;
    logic [b85d_pkg::PADPROD_W-1:0] b_val_reg;
    logic [b85d_pkg::COUNT_W-1:0]   b_k_reg;
    logic                           b_done_reg;

    logic [b85d_pkg::PAD_W-1:0]     pad_base;
    logic [b85d_pkg::PADPROD_W-1:0] pad_prod;

    // result formation
    logic [b85d_pkg::PADPROD_W-1:0]                padded;
    logic [b85d_pkg::COUNT_W-1:0]                  res_count;
    logic                                          res_bytes;
    logic [b85d_pkg::GROUP_W-1:0]                  res_word;
    logic                                          res_done;
    logic                                          lane_last;
    b85d_pkg::out_word_t [b85d_pkg::LANES-1:0]     lanes;

    logic [b85d_pkg::FILL_W-1:0] room;
    logic                        ins_ok;
    logic                        ins_go;
    logic                        b_free;
    logic                        a_go;

    assign ins_ok  = {1'b0, res_count} <= room;
    assign ins_go  = b_valid_reg && ins_ok;
    assign b_free  = !b_valid_reg || ins_ok;
    assign a_go    = a_valid_reg && b_free;
    assign s_ready = !a_valid_reg || b_free;
    assign accept  = s_valid && s_ready;

    always_comb begin
        digit     = b85d_pkg::digit_of(s_data.char_code);
        prod      = b85d_pkg::PROD_W'(group_reg) * b85d_pkg::PROD_W'(b85d_pkg::RADIX)
                    + b85d_pkg::PROD_W'(digit);
        count_inc = digits_reg + b85d_pkg::COUNT_W'(1);

        group_next  = group_reg;
        digits_next = digits_reg;
        failed_next = failed_reg;
        ev_valid    = 1'b0;
        ev_kind     = b85d_pkg::EV_ERROR;
        ev_val      = prod[b85d_pkg::GROUP_W-1:0];
        ev_k        = count_inc;
        ev_done     = s_data.string_end;

        if (accept) begin
            if (failed_reg) begin
                if (s_data.string_end) begin
                    failed_next = 1'b0;
                    group_next  = '0;
                    digits_next = '0;
                end
            end else if (digit > b85d_pkg::TOP_DIGIT
                         || prod[b85d_pkg::PROD_W-1:b85d_pkg::GROUP_W] != '0) begin
                ev_valid    = 1'b1;
                ev_kind     = b85d_pkg::EV_ERROR;
                group_next  = '0;
                digits_next = '0;
                failed_next = !s_data.string_end;
            end else if (count_inc == b85d_pkg::GROUP_DIGITS) begin
                ev_valid    = 1'b1;
                ev_kind     = b85d_pkg::EV_FULL;
                group_next  = '0;
                digits_next = '0;
            end else if (s_data.string_end) begin
                ev_valid    = 1'b1;
                ev_kind     = b85d_pkg::EV_PART;
                group_next  = '0;
                digits_next = '0;
            end else begin
                group_next  = prod[b85d_pkg::GROUP_W-1:0];
                digits_next = count_inc;
            end
        end
    end

    assign a_valid_next = ev_valid ? 1'b1 : (a_go ? 1'b0 : a_valid_reg);
    assign b_valid_next = a_go ? 1'b1 : (ins_go ? 1'b0 : b_valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            group_reg   <= '0;
            digits_reg  <= '0;
            failed_reg  <= 1'b0;
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end else begin
            group_reg   <= group_next;
            digits_reg  <= digits_next;
            failed_reg  <= failed_next;
            a_valid_reg <= a_valid_next;
            b_valid_reg <= b_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ev_valid) begin
            a_kind_reg <= ev_kind;
            a_val_reg  <= ev_val;
            a_k_reg    <= ev_k;
            a_done_reg <= ev_done;
        end
    end

    // padded group = (value + 1) * 85^pads - 1
    assign pad_base = a_val_reg[b85d_pkg::PAD_W-1:0] + b85d_pkg::PAD_W'(1);
    assign pad_prod = b85d_pkg::PADPROD_W'(pad_base)
                      * b85d_pkg::PADPROD_W'(b85d_pkg::pad_scale(a_k_reg));

    always_ff @(posedge aclk) begin
        if (a_go) begin
            b_kind_reg <= a_kind_reg;
            b_val_reg  <= (a_kind_reg == b85d_pkg::EV_PART) ? pad_prod
                          : b85d_pkg::PADPROD_W'(a_val_reg);
            b_k_reg    <= a_k_reg;
            b_done_reg <= a_done_reg;
        end
    end

    always_comb begin
        padded    = b_val_reg - b85d_pkg::PADPROD_W'(1);
        res_count = '0;
        res_bytes = 1'b0;
        res_word  = b_val_reg[b85d_pkg::GROUP_W-1:0];
        res_done  = b_done_reg;
        lane_last = 1'b0;
        lanes     = '0;

        case (b_kind_reg)
            b85d_pkg::EV_ERROR: begin
                res_count = b85d_pkg::COUNT_W'(1);
                lanes[0]  = b85d_pkg::ERR_WORD;
            end
            b85d_pkg::EV_FULL: begin
                res_count = b85d_pkg::GROUP_BYTES;
                res_bytes = 1'b1;
            end
            b85d_pkg::EV_PART: begin
                if (padded[b85d_pkg::PADPROD_W-1:b85d_pkg::GROUP_W] != '0) begin
                    res_count = b85d_pkg::COUNT_W'(1);
                    lanes[0]  = b85d_pkg::ERR_WORD;
                end else if (b_k_reg == b85d_pkg::COUNT_W'(1)) begin
                    res_count = b85d_pkg::COUNT_W'(1);
                    lanes[0]  = b85d_pkg::MARK_WORD;
                end else begin
                    res_count = b_k_reg - b85d_pkg::COUNT_W'(1);
                    res_bytes = 1'b1;
                    res_word  = padded[b85d_pkg::GROUP_W-1:0];
                    res_done  = 1'b1;
                end
            end
            default: begin
                res_count = '0;
            end
        endcase

        if (res_bytes) begin
            for (int i = 0; i < b85d_pkg::LANES; i++) begin
                lane_last               = b85d_pkg::COUNT_W'(i + 1) == res_count;
                lanes[i].data_byte      = res_word[b85d_pkg::GROUP_W-1-8*i -: 8];
                lanes[i].has_byte       = 1'b1;
                lanes[i].bad_string     = 1'b0;
                lanes[i].string_done    = lane_last && res_done;
                lanes[i].run_last       = lane_last;
            end
        end
    end

    b85d_chain u_chain (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ins_valid (ins_go),
        .ins_count (res_count),
        .ins_lanes (lanes),
        .room      (room),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    `ASSERT_ALWAYS(a_digits_range, aclk, aresetn, digits_reg < b85d_pkg::GROUP_DIGITS, "digit count reached a full group")
    `ASSERT_IMPLY(a_failed_clear, aclk, aresetn, failed_reg, group_reg == '0 && digits_reg == '0, "rejected string left a partial group")
    `ASSERT_NEXT(a_end_clears, aclk, aresetn, s_valid && s_ready && s_data.string_end, !failed_reg && digits_reg == '0 && group_reg == '0, "string end did not clear state")
    `ASSERT_NEXT(a_b_hold, aclk, aresetn, b_valid_reg && !ins_ok, b_valid_reg && $stable(b_val_reg), "stalled event changed")

endmodule

[test/b85_decode_checker.sv]
`timescale 1ns / 100ps
// Result checker for the base-85 string decoder: predicts result words and compares them.
module b85_decode_checker
    import b85d_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    input  logic      s_ready,
    input  in_word_t  s_data,
    input  logic      m_valid,
    input  logic      m_ready,
    input  out_word_t m_data,
    output int        fail_count,
    output int        pending,
    output int        words_checked,
    output int        rejects_seen
);

    localparam int          MAX_REPORTS = 20;
    localparam logic [63:0] GROUP_MAX   = 64'h0000_0000_FFFF_FFFF;
    localparam logic [7:0]  PUNCT [23]  = '{8'h21, 8'h23, 8'h24, 8'h25, 8'h26, 8'h28,
                                           8'h29, 8'h2A, 8'h2B, 8'h2D, 8'h3B, 8'h3C,
                                           8'h3D, 8'h3E, 8'h3F, 8'h40, 8'h5E, 8'h5F,
                                           8'h60, 8'h7B, 8'h7C, 8'h7D, 8'h7E};

    out_word_t    expected_words[$];
    out_word_t    want;
    logic [31:0]  group_acc;
    int           group_digits;
    logic         string_dropped;

    initial begin
        fail_count    = 0;
        pending       = 0;
        words_checked = 0;
        rejects_seen  = 0;
    end

    function automatic int unsigned digit_value(input logic [7:0] c);
        int unsigned dv;
        int          i;
        dv = 85;
        if (c >= 8'h30 && c <= 8'h39) begin
            dv = c - 8'h30;
        end else if (c >= 8'h41 && c <= 8'h5A) begin
            dv = c - 8'h41 + 10;
        end else if (c >= 8'h61 && c <= 8'h7A) begin
            dv = c - 8'h61 + 36;
        end else begin
            for (i = 0; i < 23; i++) begin
                if (c == PUNCT[i]) begin
                    dv = 62 + i;
                end
            end
        end
        return dv;
    endfunction

    task automatic push_word(input logic [7:0] b, input logic has, input logic bad,
                             input logic done, input logic last);
        out_word_t w;
        w.data_byte   = b;
        w.has_byte    = has;
        w.bad_string  = bad;
        w.string_done = done;
        w.run_last    = last;
        expected_words.push_back(w);
    endtask

    task automatic reject_string(input logic at_end);
        group_acc      = '0;
        group_digits   = 0;
        string_dropped = !at_end;
        push_word(8'h00, 1'b0, 1'b1, 1'b1, 1'b1);
    endtask

    task automatic push_bytes(input logic [31:0] v, input int n, input logic done);
        int i;
        for (i = 0; i < n; i++) begin
            push_word(v[31:24], 1'b1, 1'b0, (i == n - 1) && done, i == n - 1);
            v = v << 8;
        end
    endtask

    task automatic predict_char(input in_word_t w);
        int unsigned dv;
        logic [63:0] acc;
        logic [31:0] g;
        int          k;
        int          i;
        if (string_dropped) begin
            if (w.string_end) begin
                string_dropped = 1'b0;
                group_acc      = '0;
                group_digits   = 0;
            end
            return;
        end
        dv = digit_value(w.char_code);
        if (dv > 84) begin
            reject_string(w.string_end);
            return;
        end
        acc = {32'd0, group_acc} * 64'd85 + 64'(dv);
        if (acc > GROUP_MAX) begin
            reject_string(w.string_end);
            return;
        end
        group_acc    = acc[31:0];
        group_digits = group_digits + 1;
        if (group_digits == 5) begin
            g            = group_acc;
            group_acc    = '0;
            group_digits = 0;
            push_bytes(g, 4, w.string_end);
            return;
        end
        if (!w.string_end) begin
            return;
        end
        // pad the short final group with the top digit
        k   = group_digits;
        acc = {32'd0, group_acc};
        for (i = k; i < 5; i++) begin
            acc = acc * 64'd85 + 64'd84;
        end
        group_acc    = '0;
        group_digits = 0;
        if (acc > GROUP_MAX) begin
            reject_string(1'b1);
        end else if (k <= 1) begin
            push_word(8'h00, 1'b0, 1'b0, 1'b1, 1'b1);
        end else begin
            push_bytes(acc[31:0], k - 1, 1'b1);
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            group_acc      = '0;
            group_digits   = 0;
            string_dropped = 1'b0;
            expected_words.delete();
        end else begin
            if (s_valid && s_ready) begin
                predict_char(s_data);
            end
            if (m_valid && m_ready) begin
                words_checked++;
                if (m_data.bad_string === 1'b1) begin
                    rejects_seen++;
                end
                if (expected_words.size() == 0) begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS) begin
                        $display("%0t: unexpected word: expected none, actual byte=%02h has=%b bad=%b done=%b last=%b",
                                 $time, m_data.data_byte, m_data.has_byte, m_data.bad_string,
                                 m_data.string_done, m_data.run_last);
                    end
                end else begin
                    want = expected_words.pop_front();
                    if (m_data.data_byte !== want.data_byte || m_data.has_byte !== want.has_byte
                        || m_data.bad_string !== want.bad_string
                        || m_data.string_done !== want.string_done
                        || m_data.run_last !== want.run_last) begin
                        fail_count++;
                        if (fail_count <= MAX_REPORTS) begin
                            $display("%0t: word mismatch: expected byte=%02h has=%b bad=%b done=%b last=%b, actual byte=%02h has=%b bad=%b done=%b last=%b",
                                     $time, want.data_byte, want.has_byte, want.bad_string,
                                     want.string_done, want.run_last, m_data.data_byte,
                                     m_data.has_byte, m_data.bad_string, m_data.string_done,
                                     m_data.run_last);
                        end
                    end
                end
            end
        end
        pending = expected_words.size();
    end

endmodule

[test/tb_top.sv]
`timescale 1ns / 100ps
// Testbench top for the base-85 string decoder: clock, reset, stimulus and verdict.
module tb_top;
    import b85d_pkg::*;

    localparam int HOLD_CYCLES  = 300;
    localparam int WATCH_LIMIT  = 4000;
    localparam int TAIL_CYCLES  = 24;
    localparam int RANDOM_CHARS = 335;

    localparam logic [7:0] PUNCT [23] = '{8'h21, 8'h23, 8'h24, 8'h25, 8'h26, 8'h28,
                                          8'h29, 8'h2A, 8'h2B, 8'h2D, 8'h3B, 8'h3C,
                                          8'h3D, 8'h3E, 8'h3F, 8'h40, 8'h5E, 8'h5F,
                                          8'h60, 8'h7B, 8'h7C, 8'h7D, 8'h7E};
    localparam logic [7:0] ODD_CHARS [10] = '{8'h22, 8'h27, 8'h2C, 8'h2E, 8'h2F,
                                              8'h3A, 8'h5B, 8'h5C, 8'h5D, 8'h7F};

    typedef enum int {
        FILL_RANDOM,
        FILL_ONES,
        FILL_ZEROS
    } fill_mode_t;

    logic      aclk;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    in_word_t  s_data;
    logic      m_valid;
    logic      m_ready;
    out_word_t m_data;

    int fail_count;
    int pending;
    int words_checked;
    int rejects_seen;

    logic       hold_req;
    bit         calm;
    int         chars_sent;
    int         strings_sent;
    int         quiet_cycles;
    logic [7:0] str_q[$];

    base85_string_decoder dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    b85_decode_checker checker_i (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_data        (s_data),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_data        (m_data),
        .fail_count    (fail_count),
        .pending       (pending),
        .words_checked (words_checked),
        .rejects_seen  (rejects_seen)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // receiver: random stalls, one long hold-off on request
    initial begin
        bit hold_done;
        hold_done = 1'b0;
        m_ready   = 1'b0;
        wait (aresetn);
        forever begin
            @(posedge aclk);
            if (hold_req && !hold_done) begin
                hold_done = 1'b1;
                m_ready  <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(posedge aclk);
            end else if (calm) begin
                m_ready <= 1'b1;
            end else begin
                m_ready <= ($urandom_range(0, 99) >= 27);
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            quiet_cycles <= 0;
        end else if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCH_LIMIT) begin
                $display("%0t: watchdog expired with %0d words outstanding", $time, pending);
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    function automatic logic [7:0] sym(input int unsigned d);
        if (d < 10) begin
            return 8'(8'h30 + d);
        end else if (d < 36) begin
            return 8'(8'h41 + d - 10);
        end else if (d < 62) begin
            return 8'(8'h61 + d - 36);
        end
        return PUNCT[d - 62];
    endfunction

    function automatic logic [7:0] bad_char();
        int r;
        r = $urandom_range(0, 2);
        if (r == 0) begin
            return 8'h80 | 8'($urandom_range(0, 127));
        end else if (r == 1) begin
            return 8'($urandom_range(0, 32));
        end
        return ODD_CHARS[$urandom_range(0, 9)];
    endfunction

    task automatic add_encoded(input int nbytes, input fill_mode_t mode);
        logic [31:0] v;
        logic [7:0]  b;
        int unsigned dg [5];
        int          left;
        int          n;
        int          i;
        int          k;
        left = nbytes;
        while (left > 0) begin
            n = (left > 4) ? 4 : left;
            v = '0;
            for (i = 0; i < 4; i++) begin
                if (i >= n || mode == FILL_ZEROS) begin
                    b = 8'h00;
                end else if (mode == FILL_ONES || $urandom_range(0, 3) == 0) begin
                    b = 8'hFF;
                end else begin
                    b = 8'($urandom);
                end
                v = {v[23:0], b};
            end
            for (k = 4; k >= 0; k--) begin
                dg[k] = v % 32'd85;
                v     = v / 32'd85;
            end
            for (k = 0; k <= n; k++) begin
                str_q.push_back(sym(dg[k]));
            end
            left -= n;
        end
    endtask

    task automatic send_char(input logic [7:0] c, input logic last);
        if (!calm && $urandom_range(0, 99) < 25) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 2)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= '{char_code: c, string_end: last};
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        chars_sent++;
    endtask

    task automatic send_string();
        int i;
        for (i = 0; i < str_q.size(); i++) begin
            send_char(str_q[i], i == str_q.size() - 1);
        end
        strings_sent++;
        str_q.delete();
    endtask

    task automatic drain_wait();
        s_valid <= 1'b0;
        @(negedge aclk);
        while (pending != 0) @(negedge aclk);
        @(posedge aclk);
    endtask

    task automatic build_random_string();
        int r;
        int i;
        int n;
        r = $urandom_range(0, 99);
        if (r < 62) begin
            add_encoded($urandom_range(1, 10), FILL_RANDOM);
        end else if (r < 72) begin
            add_encoded($urandom_range(1, 8), FILL_RANDOM);
            str_q[$urandom_range(0, str_q.size() - 1)] = bad_char();
            n = $urandom_range(0, 3);
            for (i = 0; i < n; i++) begin
                str_q.push_back(sym($urandom_range(0, 84)));
            end
        end else if (r < 82) begin
            if ($urandom_range(0, 1) == 1) begin
                add_encoded(4, FILL_RANDOM);
            end
            str_q.push_back(sym($urandom_range(82, 84)));
            n = $urandom_range(1, 6);
            for (i = 0; i < n; i++) begin
                str_q.push_back(sym($urandom_range(0, 84)));
            end
        end else if (r < 90) begin
            add_encoded(4 * $urandom_range(0, 1), FILL_RANDOM);
            str_q.push_back(sym($urandom_range(0, 84)));
        end else begin
            n = $urandom_range(1, 8);
            for (i = 0; i < n; i++) begin
                str_q.push_back(8'($urandom));
            end
        end
    endtask

    initial begin
        bit hold_started;
        bit pause_done;
        int rand_end;
        aresetn      = 1'b0;
        s_valid      = 1'b0;
        s_data       = '0;
        hold_req     = 1'b0;
        calm         = 1'b0;
        chars_sent   = 0;
        strings_sent = 0;
        hold_started = 1'b0;
        pause_done   = 1'b0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // single-digit final group
        str_q.push_back("0");
        send_string();
        // largest group value
        add_encoded(4, FILL_ONES);
        send_string();
        // overflow on the fifth digit, which is also the last character
        repeat (5) str_q.push_back("~");
        send_string();
        // overflow mid-string, then drop the rest
        str_q = '{8'h7C, "N", "s", "C", "1", "0"};
        send_string();
        // invalid character as the last one
        str_q.push_back(8'hFF);
        send_string();
        // padding overflow of a four-digit final group
        str_q = '{8'h7C, "N", "s", "D"};
        send_string();
        // invalid character first, then drop
        str_q = '{8'h20, "A"};
        send_string();

        rand_end = chars_sent + RANDOM_CHARS;
        while (chars_sent < rand_end) begin
            if (!hold_started && chars_sent >= 130) begin
                hold_started = 1'b1;
                hold_req    <= 1'b1;
            end
            if (!pause_done && chars_sent >= 220) begin
                pause_done = 1'b1;
                drain_wait();
            end
            calm = (chars_sent >= 260 && chars_sent < 340);
            build_random_string();
            send_string();
        end
        calm = 1'b0;

        drain_wait();
        repeat (TAIL_CYCLES) @(posedge aclk);

        $display("covered %0d characters in %0d strings; %0d result words checked, %0d rejections",
                 chars_sent, strings_sent, words_checked, rejects_seen);
        $display("included a %0d-cycle receiver hold-off and a full drain pause", HOLD_CYCLES);
        if (pending != 0) begin
            $display("%0t: %0d expected words never arrived", $time, pending);
        end
        if (fail_count == 0 && pending == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

[base85_string_decoder.f]
+incdir+hdl
hdl/b85d_pkg.sv
hdl/b85d_cell.sv
hdl/b85d_chain.sv
hdl/base85_string_decoder.sv
test/b85_decode_checker.sv
test/tb_top.sv
